// File: rtl/core/cfc_pkg.sv
`default_nettype none

package cfc_pkg;

  // Tap chain depth
  localparam int MAX_TAPS = 32;
  localparam int IDX_W    = $clog2(MAX_TAPS);
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);

  // Fixed field widths
  localparam int SMP_W    = 16;
  localparam int ACC_W    = 40;
  localparam int CFG_W    = 6;
  localparam int MODE_W   = 2;
  localparam int TIDX_W   = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // Sequencer to datapath
  typedef struct packed {
    logic ready;
    logic push;
    logic zero;
    logic clear;
    logic emit;
    logic last;
  } ctrl_t;

  // Per-cell control
  typedef struct packed {
    logic push;
    logic clear;
    logic coef_we;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/cfc_if.sv
`default_nettype none

interface cfc_feed_if;
  logic                                valid;
  logic                                ready;
  logic [cfc_pkg::MODE_W-1:0]          mode;
  logic [cfc_pkg::TIDX_W-1:0]          tap_index;
  logic signed [cfc_pkg::SMP_W-1:0]    tap_re;
  logic signed [cfc_pkg::SMP_W-1:0]    tap_im;
  logic signed [cfc_pkg::SMP_W-1:0]    sample_re;
  logic signed [cfc_pkg::SMP_W-1:0]    sample_im;

  modport source (
    output valid, mode, tap_index, tap_re, tap_im, sample_re, sample_im,
    input  ready
  );
  modport sink (
    input  valid, mode, tap_index, tap_re, tap_im, sample_re, sample_im,
    output ready
  );
endinterface

interface cfc_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [cfc_pkg::ACC_W-1:0]    out_re;
  logic signed [cfc_pkg::ACC_W-1:0]    out_im;
  logic                                tail_last;

  modport source (
    output valid, out_re, out_im, tail_last,
    input  ready
  );
  modport sink (
    input  valid, out_re, out_im, tail_last,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/cfc_tap_cell.sv
`default_nettype none

module cfc_tap_cell (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire cfc_pkg::cell_ctrl_t               ctrl,
  input  wire logic signed [cfc_pkg::SMP_W-1:0]  tap_re,
  input  wire logic signed [cfc_pkg::SMP_W-1:0]  tap_im,
  input  wire logic signed [cfc_pkg::SMP_W-1:0]  hist_re_prev,
  input  wire logic signed [cfc_pkg::SMP_W-1:0]  hist_im_prev,
  input  wire logic signed [cfc_pkg::ACC_W-1:0]  psum_re_prev,
  input  wire logic signed [cfc_pkg::ACC_W-1:0]  psum_im_prev,
  output logic signed [cfc_pkg::SMP_W-1:0]       hist_re,
  output logic signed [cfc_pkg::SMP_W-1:0]       hist_im,
  output logic signed [cfc_pkg::ACC_W-1:0]       psum_re,
  output logic signed [cfc_pkg::ACC_W-1:0]       psum_im
);

  logic signed [cfc_pkg::SMP_W-1:0]   coef_re;
  logic signed [cfc_pkg::SMP_W-1:0]   coef_im;
  logic signed [2*cfc_pkg::SMP_W-1:0] ac, bd, ad, bc;
  logic signed [2*cfc_pkg::SMP_W:0]   prod_re, prod_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_re <= '0;
      coef_im <= '0;
      hist_re <= '0;
      hist_im <= '0;
    end else begin
      if (ctrl.coef_we) begin
        coef_re <= tap_re;
        coef_im <= tap_im;
      end
      if (ctrl.clear) begin
        hist_re <= '0;
        hist_im <= '0;
      end else if (ctrl.push) begin
        hist_re <= hist_re_prev;
        hist_im <= hist_im_prev;
      end
    end
  end

  // (a + jb)(c + jd)
  always_comb begin
    ac      = coef_re * hist_re;
    bd      = coef_im * hist_im;
    ad      = coef_re * hist_im;
    bc      = coef_im * hist_re;
    prod_re = (2*cfc_pkg::SMP_W+1)'(ac) - (2*cfc_pkg::SMP_W+1)'(bd);
    prod_im = (2*cfc_pkg::SMP_W+1)'(ad) + (2*cfc_pkg::SMP_W+1)'(bc);
  end

  // partial sum ripples one cell per clock
  always_ff @(posedge clk) begin
    psum_re <= psum_re_prev + cfc_pkg::ACC_W'(prod_re);
    psum_im <= psum_im_prev + cfc_pkg::ACC_W'(prod_im);
  end

endmodule

`default_nettype wire

// File: rtl/core/cfc_ctrl.sv
`default_nettype none

module cfc_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [cfc_pkg::CNT_W-1:0]  taps,
  input  wire logic                       in_valid,
  input  wire cfc_pkg::mode_t             in_mode,
  input  wire logic                       out_free,
  output cfc_pkg::ctrl_t                  ctrl
);

  cfc_pkg::state_t            state, state_next;
  logic [cfc_pkg::CNT_W-1:0]  cnt;
  logic [cfc_pkg::CNT_W-1:0]  left;
  logic                       flushing;
  logic                       accept;
  logic                       done;
  logic                       more;

  assign accept = in_valid && (state == cfc_pkg::ST_IDLE);
  assign done   = (state == cfc_pkg::ST_RUN) && (cnt == taps);
  assign more   = flushing && (left > cfc_pkg::CNT_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      cfc_pkg::ST_IDLE: begin
        if (accept && (in_mode == cfc_pkg::MODE_SAMPLE ||
                       (in_mode == cfc_pkg::MODE_FLUSH && taps > cfc_pkg::CNT_W'(1)))) begin
          state_next = cfc_pkg::ST_RUN;
        end
      end
      cfc_pkg::ST_RUN: begin
        if (done && out_free && !more) begin
          state_next = cfc_pkg::ST_IDLE;
        end
      end
      default: state_next = cfc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl       = '0;
    ctrl.ready = (state == cfc_pkg::ST_IDLE);
    ctrl.emit  = done && out_free;
    ctrl.last  = flushing && (left == cfc_pkg::CNT_W'(1));
    if (accept) begin
      case (in_mode)
        cfc_pkg::MODE_SAMPLE: ctrl.push = 1'b1;
        cfc_pkg::MODE_FLUSH: begin
          if (taps > cfc_pkg::CNT_W'(1)) begin
            ctrl.push = 1'b1;
            ctrl.zero = 1'b1;
          end else begin
            ctrl.clear = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (done && out_free && flushing) begin
      if (more) begin
        ctrl.push = 1'b1;
        ctrl.zero = 1'b1;
      end else begin
        ctrl.clear = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cfc_pkg::ST_IDLE;
      cnt      <= '0;
      left     <= '0;
      flushing <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.push) begin
        cnt <= '0;
      end else if (state == cfc_pkg::ST_RUN && !done) begin
        cnt <= cnt + cfc_pkg::CNT_W'(1);
      end
      if (accept) begin
        flushing <= (in_mode == cfc_pkg::MODE_FLUSH);
        left     <= taps - cfc_pkg::CNT_W'(1);
      end else if (done && out_free && flushing) begin
        left <= left - cfc_pkg::CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/complex_fir_convolver_core.sv
`default_nettype none

// Complex FIR convolver, Q1.15 taps and samples, exact Q10.30 40-bit outputs.
// A feed beat with mode 0 loads one complex tap (a tap index at or above the
// chain depth is dropped); mode 1 shifts one sample into the delay line and
// yields one result beat; mode 2 runs tap_count-1 zero samples through the
// line, yields one result beat per zero with tail_last set on the final one,
// and then clears the delay line. Mode 3 is dropped. tap_count is written
// through cfg_we/cfg_data, only while the core is idle, which the user must
// ensure as the core does not enforce it; 0 acts as 1 and values above the
// chain depth act as the depth. Structure: a row of tap cells, each holding
// one coefficient and one delay line sample and adding its complex product
// to the partial sum handed on by its left neighbor, one cell per clock.
// With N the tap count in use after clamping, a load leaves the core idle;
// a sample beat occupies the core while the partial sum ripples through N
// cells; a flush does so once for each of its N-1 zero samples. Results sit
// in an output register, so the next feed beat is taken while a result still
// waits on the result channel; a stalled result channel holds the chain until
// the register is free.

module complex_fir_convolver_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [cfc_pkg::CFG_W-1:0]   cfg_data,
  cfc_feed_if.sink                         feed,
  cfc_result_if.source                     result
);

  logic [cfc_pkg::CFG_W-1:0]               tap_count;
  logic [cfc_pkg::CNT_W-1:0]               taps;
  cfc_pkg::ctrl_t                          ctrl;
  logic                                    out_free;
  logic                                    load;
  logic [cfc_pkg::IDX_W-1:0]               sel;
  logic signed [cfc_pkg::SMP_W-1:0]        head_re, head_im;

  logic signed [cfc_pkg::SMP_W-1:0]        hist_re [cfc_pkg::MAX_TAPS];
  logic signed [cfc_pkg::SMP_W-1:0]        hist_im [cfc_pkg::MAX_TAPS];
  logic signed [cfc_pkg::ACC_W-1:0]        psum_re [cfc_pkg::MAX_TAPS];
  logic signed [cfc_pkg::ACC_W-1:0]        psum_im [cfc_pkg::MAX_TAPS];

  // tap count register
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= cfc_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      tap_count <= cfg_data;
    end
  end

  // clamp into 1..MAX_TAPS
  always_comb begin
    if (tap_count == '0) begin
      taps = cfc_pkg::CNT_W'(1);
    end else if (int'(tap_count) > cfc_pkg::MAX_TAPS) begin
      taps = cfc_pkg::CNT_W'(cfc_pkg::MAX_TAPS);
    end else begin
      taps = cfc_pkg::CNT_W'(tap_count);
    end
  end

  assign out_free = !result.valid || result.ready;

  cfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .taps     (taps),
    .in_valid (feed.valid),
    .in_mode  (cfc_pkg::mode_t'(feed.mode)),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  assign feed.ready = ctrl.ready;
  assign load       = feed.valid && ctrl.ready &&
                      (feed.mode == cfc_pkg::MODE_LOAD);

  // newest sample enters cell 0; zeros during a flush
  assign head_re = ctrl.zero ? '0 : feed.sample_re;
  assign head_im = ctrl.zero ? '0 : feed.sample_im;

  for (genvar k = 0; k < cfc_pkg::MAX_TAPS; k++) begin : g_cell
    cfc_pkg::cell_ctrl_t              cc;
    logic signed [cfc_pkg::SMP_W-1:0] prev_re, prev_im;
    logic signed [cfc_pkg::ACC_W-1:0] sum_re, sum_im;

    assign cc.push    = ctrl.push;
    assign cc.clear   = ctrl.clear;
    assign cc.coef_we = load && (int'(feed.tap_index) == k);

    if (k == 0) begin : g_head
      assign prev_re = head_re;
      assign prev_im = head_im;
      assign sum_re  = '0;
      assign sum_im  = '0;
    end else begin : g_body
      assign prev_re = hist_re[k-1];
      assign prev_im = hist_im[k-1];
      assign sum_re  = psum_re[k-1];
      assign sum_im  = psum_im[k-1];
    end

    cfc_tap_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (cc),
      .tap_re       (feed.tap_re),
      .tap_im       (feed.tap_im),
      .hist_re_prev (prev_re),
      .hist_im_prev (prev_im),
      .psum_re_prev (sum_re),
      .psum_im_prev (sum_im),
      .hist_re      (hist_re[k]),
      .hist_im      (hist_im[k]),
      .psum_re      (psum_re[k]),
      .psum_im      (psum_im[k])
    );
  end

  // full sum leaves the last cell in use
  assign sel = cfc_pkg::IDX_W'(taps - cfc_pkg::CNT_W'(1));

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ctrl.emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      result.out_re    <= psum_re[sel];
      result.out_im    <= psum_im[sel];
      result.tail_last <= ctrl.last;
    end
  end

endmodule

`default_nettype wire
